// ----- rtl/tfc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfc_pkg
// Shared widths, register indexes, reset values and the divider cell type.
// ----------------------------------------------------------------------------
package tfc_pkg;

  localparam int TIME_BITS       = 24;
  localparam int RATIO_FRAC_BITS = 16;
  localparam int RATIO_BITS      = RATIO_FRAC_BITS + 2;
  localparam int STAMP_BITS      = 63;
  localparam int OUT_BITS        = TIME_BITS + 2;
  // numerator / quotient width: offset-added time shifted by the fraction bits
  localparam int NUM_W           = TIME_BITS + 1 + RATIO_FRAC_BITS;
  // divisor width: wide enough for a ratio or a time register
  localparam int DIV_W           = (TIME_BITS > RATIO_BITS) ? TIME_BITS : RATIO_BITS;
  localparam int CFG_IDX_BITS    = 3;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_OFFSET = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_TOF_ORIGIN   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_WRAP_PERIOD  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SKIP_MODE    = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_PATH_ENABLE  = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_LOW_CUT      = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_HIGH_CUT     = 3'd7;

  localparam logic [TIME_BITS-1:0] FRAME_WIDTH_RST = TIME_BITS'(166667);
  localparam logic [TIME_BITS-1:0] WRAP_PERIOD_RST = TIME_BITS'(166667);

  // data handed from one divider cell to the next
  typedef struct packed {
    logic             vld;
    logic [DIV_W-1:0] rem;
    logic [NUM_W-1:0] nq;   // numerator bits shift out, quotient bits shift in
    logic [DIV_W-1:0] dv;
  } cell_t;

endpackage

// ----- rtl/tfc_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfc_if
// Event, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface tfc_evt_if;
  logic                                valid;
  logic                                ready;
  logic [tfc_pkg::TIME_BITS-1:0]       event_time;
  logic [tfc_pkg::RATIO_BITS-1:0]      path_ratio;
  logic [tfc_pkg::STAMP_BITS-1:0]      pulse_stamp;
  modport source (output valid, event_time, path_ratio, pulse_stamp, input ready);
  modport sink   (input valid, event_time, path_ratio, pulse_stamp, output ready);
endinterface

interface tfc_res_if;
  logic                                valid;
  logic                                ready;
  logic [tfc_pkg::OUT_BITS-1:0]        corrected_time;
  logic [tfc_pkg::STAMP_BITS-1:0]      out_pulse_stamp;
  modport source (output valid, corrected_time, out_pulse_stamp, input ready);
  modport sink   (input valid, corrected_time, out_pulse_stamp, output ready);
endinterface

interface tfc_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [tfc_pkg::CFG_IDX_BITS-1:0]    index;
  logic [tfc_pkg::TIME_BITS-1:0]       data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/tfc_div_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfc_div_cell
// One restoring-division step: resolve one quotient bit and pass it on.
// ----------------------------------------------------------------------------
module tfc_div_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tfc_pkg::cell_t cell_i,
  output tfc_pkg::cell_t cell_o
);

  logic [tfc_pkg::DIV_W:0]   shifted;
  logic                      ge;
  logic [tfc_pkg::DIV_W:0]   diff;
  tfc_pkg::cell_t            cell_d, cell_q;

  // bring down the next numerator bit and trial-subtract
  always_comb begin
    shifted = {cell_i.rem, cell_i.nq[tfc_pkg::NUM_W-1]};
    ge      = shifted >= {1'b0, cell_i.dv};
    diff    = shifted - {1'b0, cell_i.dv};
    cell_d.vld = cell_i.vld;
    cell_d.dv  = cell_i.dv;
    cell_d.rem = ge ? diff[tfc_pkg::DIV_W-1:0] : shifted[tfc_pkg::DIV_W-1:0];
    cell_d.nq  = {cell_i.nq[tfc_pkg::NUM_W-2:0], ge};
  end

  // advance the beat one cell down the row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// ----- rtl/tof_event_frame_correct_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tof_event_frame_correct_core
// Frame offset, path correction, wrap to origin, frame cuts and skip shift.
// ----------------------------------------------------------------------------
// Sequence: an accepted event steps through the sequencer states; the path
//   division, the wrap count and the frame modulo each take one pass through
//   the shared chain of NUM_W (41) divider cells when used.
// Throughput: a new event is taken only once the last one has left the
//   sequencer; a stalled result holds the sequencer in its last step.
// Reset: asynchronous, active low; configuration registers return to their
//   defaults and the sequencer and result register empty.
module tof_event_frame_correct_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  tfc_evt_if.sink   evt,
  tfc_res_if.source res,
  tfc_cfg_if.sink   cfg
);

  localparam int TB = tfc_pkg::TIME_BITS;
  localparam int NW = tfc_pkg::NUM_W;
  localparam int DW = tfc_pkg::DIV_W;
  localparam int OB = tfc_pkg::OUT_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_D1   = 3'd1;
  localparam logic [2:0] S_W1   = 3'd2;
  localparam logic [2:0] S_WR   = 3'd3;
  localparam logic [2:0] S_W2   = 3'd4;
  localparam logic [2:0] S_MD   = 3'd5;
  localparam logic [2:0] S_W3   = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  // configuration registers
  logic [TB-1:0] offset_q, origin_q, fw_q, wp_q, lc_q, hc_q;
  logic          skip_q, pen_q;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      origin_q <= '0;
      fw_q     <= tfc_pkg::FRAME_WIDTH_RST;
      wp_q     <= tfc_pkg::WRAP_PERIOD_RST;
      skip_q   <= 1'b0;
      pen_q    <= 1'b0;
      lc_q     <= '0;
      hc_q     <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        tfc_pkg::REG_FRAME_OFFSET: offset_q <= cfg.data;
        tfc_pkg::REG_TOF_ORIGIN:   origin_q <= cfg.data;
        tfc_pkg::REG_FRAME_WIDTH:  fw_q     <= cfg.data;
        tfc_pkg::REG_WRAP_PERIOD:  wp_q     <= cfg.data;
        tfc_pkg::REG_SKIP_MODE:    skip_q   <= cfg.data[0];
        tfc_pkg::REG_PATH_ENABLE:  pen_q    <= cfg.data[0];
        tfc_pkg::REG_LOW_CUT:      lc_q     <= cfg.data;
        tfc_pkg::REG_HIGH_CUT:     hc_q     <= cfg.data;
        default:                   offset_q <= offset_q;
      endcase
    end
  end

  // divider chain
  tfc_pkg::cell_t link [NW+1];
  tfc_pkg::cell_t launch;

  assign link[0] = launch;

  for (genvar g = 0; g < NW; g++) begin : g_cell
    tfc_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (link[g]),
      .cell_o (link[g+1])
    );
  end

  tfc_pkg::cell_t done;
  assign done = link[NW];

  // sequencer state and working values
  logic [2:0]                   state_q, state_d;
  logic [NW-1:0]                t_q, t_d, rel_q, rel_d, x_q, x_d;
  logic [tfc_pkg::RATIO_BITS-1:0] ratio_q;
  logic [tfc_pkg::STAMP_BITS-1:0] stamp_q;
  logic                         res_vld_q, res_vld_d;
  logic [OB-1:0]                res_time_q, res_time_d;
  logic                         load_out;

  logic [TB-1:0]                w_eff;
  logic [TB:0]                  wrap_num, wrap_t;
  logic                         keep;
  logic [NW:0]                  t_fin;
  logic                         out_free;

  assign w_eff    = (wp_q == '0) ? TB'(1) : wp_q;
  assign wrap_num = {1'b0, origin_q} - t_q[TB:0] + {1'b0, w_eff} - (TB+1)'(1);
  assign wrap_t   = {1'b0, origin_q} + {1'b0, w_eff - TB'(1) - done.rem[TB-1:0]};
  assign keep     = !(x_q < NW'(lc_q)) &&
                    !(({1'b0, x_q} + (NW+1)'(hc_q)) > (NW+1)'(fw_q));
  assign t_fin    = (skip_q && (rel_q > NW'(fw_q))) ? ({1'b0, t_q} + (NW+1)'(fw_q))
                                                    : {1'b0, t_q};
  assign out_free = !res_vld_q || res.ready;
  assign evt.ready = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    t_d        = t_q;
    rel_d      = rel_q;
    x_d        = x_q;
    launch     = '0;
    load_out   = 1'b0;
    res_time_d = res_time_q;
    unique case (state_q)
      S_IDLE: begin
        if (evt.valid) begin
          t_d     = NW'({1'b0, evt.event_time} + {1'b0, offset_q});
          state_d = S_D1;
        end
      end
      S_D1: begin
        // divide by the path ratio when enabled and the ratio is nonzero
        if (pen_q && ratio_q != '0) begin
          launch.vld = 1'b1;
          launch.nq  = {t_q[TB:0], {tfc_pkg::RATIO_FRAC_BITS{1'b0}}};
          launch.dv  = DW'(ratio_q);
          state_d    = S_W1;
        end else begin
          state_d = S_WR;
        end
      end
      S_W1: begin
        if (done.vld) begin
          t_d     = done.nq;
          state_d = S_WR;
        end
      end
      S_WR: begin
        // raise below-origin times by whole wrap periods
        if (t_q < NW'(origin_q)) begin
          launch.vld = 1'b1;
          launch.nq  = NW'(wrap_num);
          launch.dv  = DW'(w_eff);
          state_d    = S_W2;
        end else begin
          state_d = S_MD;
        end
      end
      S_W2: begin
        if (done.vld) begin
          t_d     = NW'(wrap_t);
          state_d = S_MD;
        end
      end
      S_MD: begin
        rel_d = t_q - NW'(origin_q);
        if (fw_q != '0) begin
          launch.vld = 1'b1;
          launch.nq  = t_q - NW'(origin_q);
          launch.dv  = DW'(fw_q);
          state_d    = S_W3;
        end else begin
          x_d     = t_q - NW'(origin_q);
          state_d = S_FIN;
        end
      end
      S_W3: begin
        if (done.vld) begin
          x_d     = NW'(done.rem);
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        // drop cut events; hold a kept one until the result register frees
        if (!keep) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          load_out   = 1'b1;
          res_time_d = (|t_fin[NW:OB]) ? {OB{1'b1}} : t_fin[OB-1:0];
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign res_vld_d = load_out | (res_vld_q & ~res.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q        <= t_d;
    rel_q      <= rel_d;
    x_q        <= x_d;
    res_time_q <= res_time_d;
    if (evt.valid && evt.ready) begin
      ratio_q <= evt.path_ratio;
      stamp_q <= evt.pulse_stamp;
    end
    if (load_out) begin
      res.out_pulse_stamp <= stamp_q;
    end
  end

  assign res.valid          = res_vld_q;
  assign res.corrected_time = res_time_q;

endmodule

// ----- rtl/tfc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfc_checker
// Port-level checks on the frame correction core, bound to the top level.
// ----------------------------------------------------------------------------
module tfc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           evt_valid,
  input logic                           evt_ready,
  input logic                           res_valid,
  input logic                           res_ready,
  input logic [tfc_pkg::OUT_BITS-1:0]   res_time
);

  // an accepted event keeps the input closed for the sequencer's first steps
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (evt_valid && evt_ready) |=> !evt_ready ##1 !evt_ready ##1 !evt_ready)
    else $error("input reopened too early after an accepted beat");

  // a stalled result beat stays valid
  a_res_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !res_ready) |=> res_valid)
    else $error("result beat withdrawn while stalled");

  // a stalled result keeps its time
  a_res_hold_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !res_ready) |=> $stable(res_time))
    else $error("result time changed while stalled");

endmodule

bind tof_event_frame_correct_core tfc_checker u_tfc_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .evt_valid (evt.valid),
  .evt_ready (evt.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_time  (res.corrected_time)
);
